FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tcp_pkg.sv
package tcp_pkg;

  localparam int unsigned LINE_CAP    = 15;
  localparam int unsigned HEAD_DEPTH  = 5;
  localparam int unsigned LEN_W       = $clog2(LINE_CAP + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] CHAR_NUL = 7'h00;
  localparam logic [6:0] CHAR_LF  = 7'h0A;
  localparam logic [6:0] CHAR_CR  = 7'h0D;
  localparam logic [6:0] CHAR_NINE = 7'h39;
  localparam logic [6:0] CHAR_C   = 7'h43;
  localparam logic [6:0] CHAR_R   = 7'h52;
  localparam logic [6:0] CHAR_W   = 7'h57;
  localparam logic [6:0] CHAR_X   = 7'h78;
  localparam logic [6:0] CHAR_Y   = 7'h79;
  localparam logic [6:0] CHAR_Z   = 7'h7A;

  localparam logic [7:0] AXIS_X_LOW   = 8'h28;
  localparam logic [7:0] AXIS_Y_LOW   = 8'h2A;
  localparam logic [7:0] AXIS_Z_LOW   = 8'h2C;
  localparam logic [7:0] SPI_READ_BIT = 8'h80;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_A      = 8'h41;
  localparam logic [7:0] HEX_TEN      = 8'd10;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_AXIS  = 2'd3
  } op_e;

  // Classified line: the opcode plus the raw head characters.
  typedef struct packed {
    op_e                         op;
    logic [HEAD_DEPTH-1:0][6:0]  chars;
  } tcp_cmd_t;

  // Unchecked hex digit, modulo 256.
  function automatic logic [7:0] nibble_of(input logic [6:0] code);
    logic [7:0] wide;
    wide = {1'b0, code};
    if (code <= CHAR_NINE) begin
      nibble_of = wide - ASCII_ZERO;
    end else begin
      nibble_of = (wide & ~CASE_BIT) - ASCII_A + HEX_TEN;
    end
  endfunction

  function automatic logic [7:0] hex_byte(input logic [6:0] hi, input logic [6:0] lo);
    logic [7:0] nh;
    logic [7:0] nl;
    nh = nibble_of(hi);
    nl = nibble_of(lo);
    hex_byte = {nh[3:0], 4'h0} | nl;
  endfunction

endpackage

FILE: rtl/tcp_front.sv
module tcp_front import tcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic [6:0] char_code_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output tcp_cmd_t  q_data_o
);

  logic [HEAD_DEPTH-1:0][6:0] head_q, head_d;
  logic [LEN_W-1:0]           len_q, len_d;
  logic                       accept;
  logic                       is_eol;
  logic                       hit;
  op_e                        dec_op;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_eol     = (char_code_i == CHAR_CR) || (char_code_i == CHAR_LF);

  // Line decode from the stored head and count.
  always_comb begin
    hit    = 1'b0;
    dec_op = OP_CLEAR;
    if (len_q != '0) begin
      if (head_q[0] == CHAR_R && len_q == LEN_W'(3)) begin
        hit    = 1'b1;
        dec_op = OP_READ;
      end else if (head_q[0] == CHAR_W && len_q == LEN_W'(5)) begin
        hit    = 1'b1;
        dec_op = OP_WRITE;
      end else if (head_q[0] == CHAR_C) begin
        hit    = 1'b1;
        dec_op = OP_CLEAR;
      end else if (head_q[0] inside {CHAR_X, CHAR_Y, CHAR_Z}) begin
        hit    = 1'b1;
        dec_op = OP_AXIS;
      end
    end
  end

  always_comb begin
    head_d = head_q;
    len_d  = len_q;
    if (accept) begin
      if (is_eol) begin
        len_d = '0;
      end else if (char_code_i != CHAR_NUL && len_q < LEN_W'(LINE_CAP)) begin
        for (int i = 0; i < HEAD_DEPTH; i++) begin
          if (len_q == LEN_W'(i)) begin
            head_d[i] = char_code_i;
          end
        end
        len_d = len_q + LEN_W'(1);
      end
    end
  end

  assign q_push_o       = accept && is_eol && hit;
  assign q_data_o.op    = dec_op;
  assign q_data_o.chars = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      len_q  <= '0;
    end else begin
      head_q <= head_d;
      len_q  <= len_d;
    end
  end

endmodule

FILE: rtl/tcp_fifo.sv
module tcp_fifo import tcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tcp_cmd_t data_i,
  output logic     full_o,
  output logic     valid_o,
  output tcp_cmd_t data_o,
  input  logic     pop_i
);

  tcp_cmd_t            entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/tcp_back.sv
module tcp_back import tcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  tcp_cmd_t   q_data_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] op_o,
  output logic [7:0] reg_address_o,
  output logic [7:0] write_value_o,
  output logic [7:0] spi_first_byte_o
);

  logic       valid_q;
  logic [1:0] op_q;
  logic [7:0] addr_q, value_q, spi_q;
  logic [7:0] addr_d, value_d, spi_d;
  logic       load;

  assign load    = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o = load;

  always_comb begin
    addr_d  = '0;
    value_d = '0;
    spi_d   = '0;
    case (q_data_i.op)
      OP_READ: begin
        addr_d = hex_byte(q_data_i.chars[1], q_data_i.chars[2]);
        spi_d  = addr_d | SPI_READ_BIT;
      end
      OP_WRITE: begin
        addr_d  = hex_byte(q_data_i.chars[1], q_data_i.chars[2]);
        value_d = hex_byte(q_data_i.chars[3], q_data_i.chars[4]);
        spi_d   = addr_d;
      end
      OP_AXIS: begin
        case (q_data_i.chars[0])
          CHAR_X:  addr_d = AXIS_X_LOW;
          CHAR_Y:  addr_d = AXIS_Y_LOW;
          default: addr_d = AXIS_Z_LOW;
        endcase
        spi_d = addr_d | SPI_READ_BIT;
      end
      default: begin
        addr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q    <= q_data_i.op;
      addr_q  <= addr_d;
      value_q <= value_d;
      spi_q   <= spi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = valid_q;
  assign op_o             = op_q;
  assign reg_address_o    = addr_q;
  assign write_value_o    = value_q;
  assign spi_first_byte_o = spi_q;

endmodule

FILE: rtl/terminal_register_command_parser.sv
// Terminal command parser: takes one 7-bit ASCII character per request and
// builds a command line of up to LINE_CAP (15) kept characters; the rest are
// dropped and NUL is ignored. CR or LF closes the line, and a non-empty line
// yields at most one command request: "R" plus two hex digits (length 3) is a
// register read, "W" plus four hex digits (length 5) a register write, a line
// starting with "C" a FIFO clear, and "x", "y" or "z" an axis read at 0x28,
// 0x2A or 0x2C. Hex digits are not checked; odd digits convert modulo 256.
// Reads set bit 7 of spi_first_byte. One character is accepted every cycle
// unless in_stall is high; a line end writes its command into the queue, and
// the result register loads it when that register is empty or out_stall is low.
// The front end stalls input only when the two-entry command queue is full,
// which happens only while the output holds stall on a full result register.
module terminal_register_command_parser import tcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [6:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] op_o,
  output logic [7:0] reg_address_o,
  output logic [7:0] write_value_o,
  output logic [7:0] spi_first_byte_o
);

  // front end -> command queue
  logic     q_push;
  logic     q_full;
  tcp_cmd_t q_wdata;
  // command queue -> back end
  logic     q_valid;
  logic     q_pop;
  tcp_cmd_t q_rdata;

  // Line assembly and classification.
  tcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // Decouples line parsing from a stalled output.
  tcp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  // Hex conversion and result register.
  tcp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .op_o             (op_o),
    .reg_address_o    (reg_address_o),
    .write_value_o    (write_value_o),
    .spi_first_byte_o (spi_first_byte_o)
  );

endmodule

FILE: rtl/tcp_checker.sv
`include "assert_macros.svh"

module tcp_checker import tcp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [1:0] op_i,
  input logic [7:0] reg_address_i,
  input logic [7:0] write_value_i,
  input logic [7:0] spi_first_byte_i
);

  `TCP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(op_i) && $stable(reg_address_i) && $stable(spi_first_byte_i), "stalled request changed")

  `TCP_ASSERT_IMP(a_read_fmt, clk_i, rst_ni, out_valid_i && op_i == OP_READ, spi_first_byte_i == (reg_address_i | SPI_READ_BIT) && write_value_i == 8'h00, "bad read request")

  `TCP_ASSERT_IMP(a_write_fmt, clk_i, rst_ni, out_valid_i && op_i == OP_WRITE, spi_first_byte_i == reg_address_i, "bad write request")

  `TCP_ASSERT_IMP(a_clear_fmt, clk_i, rst_ni, out_valid_i && op_i == OP_CLEAR, reg_address_i == 8'h00 && write_value_i == 8'h00 && spi_first_byte_i == 8'h00, "bad clear request")

  `TCP_ASSERT_IMP(a_axis_fmt, clk_i, rst_ni, out_valid_i && op_i == OP_AXIS, (reg_address_i == AXIS_X_LOW || reg_address_i == AXIS_Y_LOW || reg_address_i == AXIS_Z_LOW) && spi_first_byte_i == (reg_address_i | SPI_READ_BIT) && write_value_i == 8'h00, "bad axis request")

endmodule

bind terminal_register_command_parser tcp_checker u_tcp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .op_i             (op_o),
  .reg_address_i    (reg_address_o),
  .write_value_i    (write_value_o),
  .spi_first_byte_i (spi_first_byte_o)
);
